// ----- hdl/int_to_decimal_ascii_unit_macros.svh -----
// Assertion helpers shared by the conversion unit.
// Each check is clocked on the rising edge and is disabled while reset is held.
`ifndef INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

`ifndef SYNTH
`define I2DA_ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define I2DA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define I2DA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define I2DA_ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)
`define I2DA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define I2DA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- hdl/i2da_pkg.sv -----
package i2da_pkg;

  // Converted word width and the number of decimal digits it can need
  localparam int WORD_BITS = 32;
  localparam int DIGIT_CNT = (WORD_BITS * 1233) / 4096 + 1;
  localparam int BCD_W     = DIGIT_CNT * 4;
  localparam int CNT_W     = $clog2(WORD_BITS);
  localparam int PTR_W     = (DIGIT_CNT > 1) ? $clog2(DIGIT_CNT) : 1;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);
  localparam logic [PTR_W-1:0] PTR_ZERO = '0;

  // Opcode values
  localparam logic OP_SIGNED   = 1'b0;
  localparam logic OP_UNSIGNED = 1'b1;

  // Character codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic shift;
    logic lead;
    logic emit;
  } i2da_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic conv_last;
    logic emit_last;
    logic out_free;
  } i2da_sts_t;

endpackage

// ----- hdl/i2da_datapath.sv -----
`include "int_to_decimal_ascii_unit_macros.svh"

module i2da_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_opcode,
  input  logic [i2da_pkg::WORD_BITS-1:0] in_value,
  input  i2da_pkg::i2da_cmd_t            cmd,
  output i2da_pkg::i2da_sts_t            sts,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [7:0]                     out_ascii_char,
  output logic                           out_is_last
);

  logic [i2da_pkg::WORD_BITS-1:0] bin_r;
  logic [i2da_pkg::BCD_W-1:0]     bcd_r;
  logic [i2da_pkg::CNT_W-1:0]     cnt_r;
  logic [i2da_pkg::PTR_W-1:0]     ptr_r;
  logic                           neg_r;
  logic                           sign_pend_r;
  logic                           out_valid_r;
  logic [7:0]                     out_char_r;
  logic                           out_last_r;

  logic [i2da_pkg::WORD_BITS-1:0] mag;
  logic                           neg_in;
  logic [i2da_pkg::BCD_W-1:0]     bcd_adj;
  logic [i2da_pkg::PTR_W-1:0]     lead_idx;
  logic                           bcd_ok;
  logic [3:0]                     cur_digit;
  logic [7:0]                     emit_char;
  logic                           emit_last;

  // Take the magnitude of the incoming word
  always_comb begin
    neg_in = (in_opcode == i2da_pkg::OP_SIGNED) && in_value[i2da_pkg::WORD_BITS-1];
    mag    = in_value;
    if (neg_in) begin
      mag = (~in_value) + {{(i2da_pkg::WORD_BITS-1){1'b0}}, 1'b1};
    end
  end

  // Add three to every digit of five or more ahead of the shift
  always_comb begin
    logic [3:0] dig;
    for (int i = 0; i < i2da_pkg::DIGIT_CNT; i++) begin
      dig = bcd_r[i*4 +: 4];
      bcd_adj[i*4 +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
    end
  end

  // Locate the leading nonzero digit; zero keeps the units digit
  always_comb begin
    lead_idx = i2da_pkg::PTR_ZERO;
    bcd_ok   = 1'b1;
    for (int i = 0; i < i2da_pkg::DIGIT_CNT; i++) begin
      if (bcd_r[i*4 +: 4] != 4'd0) begin
        lead_idx = i2da_pkg::PTR_W'(i);
      end
      if (bcd_r[i*4 +: 4] > 4'd9) begin
        bcd_ok = 1'b0;
      end
    end
  end

  // Pick the next character: sign first, then digits from the top
  always_comb begin
    cur_digit = bcd_r[ptr_r*4 +: 4];
    emit_char = sign_pend_r ? i2da_pkg::CHAR_MINUS : i2da_pkg::CHAR_ZERO + {4'd0, cur_digit};
    emit_last = !sign_pend_r && (ptr_r == i2da_pkg::PTR_ZERO);
  end

  // Conversion registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sign_pend_r <= 1'b0;
      neg_r       <= 1'b0;
    end else begin
      if (cmd.load) begin
        bin_r <= mag;
        bcd_r <= '0;
        cnt_r <= '0;
        neg_r <= neg_in;
      end else if (cmd.shift) begin
        bcd_r <= {bcd_adj[i2da_pkg::BCD_W-2:0], bin_r[i2da_pkg::WORD_BITS-1]};
        bin_r <= {bin_r[i2da_pkg::WORD_BITS-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.lead) begin
        ptr_r       <= lead_idx;
        sign_pend_r <= neg_r;
      end else if (cmd.emit) begin
        if (sign_pend_r) begin
          sign_pend_r <= 1'b0;
        end else if (ptr_r != i2da_pkg::PTR_ZERO) begin
          ptr_r <= ptr_r - 1'b1;
        end
      end
    end
  end

  // Output register: load on emit, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char_r <= emit_char;
      out_last_r <= emit_last;
    end
  end

  assign sts.conv_last   = (cnt_r == i2da_pkg::CNT_LAST);
  assign sts.emit_last   = emit_last;
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_ascii_char = out_char_r;
  assign out_is_last    = out_last_r;

  `I2DA_ASSERT_NEXT(a_bcd_digits, clk, rst_n, cmd.shift, bcd_ok, "digit above nine after shift")
  `I2DA_ASSERT_NEXT(a_sign_pending, clk, rst_n, cmd.lead, sign_pend_r == $past(neg_r), "sign flag not armed from negative flag")

endmodule

// ----- hdl/i2da_ctrl.sv -----
`include "int_to_decimal_ascii_unit_macros.svh"

module i2da_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2da_pkg::i2da_sts_t sts,
  output i2da_pkg::i2da_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_LEAD = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        if (sts.conv_last) begin
          state_nxt = ST_LEAD;
        end
      end
      ST_LEAD: begin
        cmd.lead  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  `I2DA_ASSERT_SAME(a_emit_free, clk, rst_n, cmd.emit, sts.out_free, "emit while output slot busy")
  `I2DA_ASSERT_NEXT(a_load_conv, clk, rst_n, in_valid && in_ready, state_r == ST_CONV, "accepted beat did not start conversion")

endmodule

// ----- hdl/int_to_decimal_ascii_unit.sv -----
// Integer to decimal ASCII converter.
// Input channel: in_valid/in_ready with in_opcode (0 = signed, 1 = unsigned)
// and a 32-bit in_value. Result channel: out_valid/out_ready, one beat per
// character, out_ascii_char most significant first, out_is_last on the final
// character. A negative signed value starts with '-'; zero gives "0".
// Timing: after an input beat is taken the word is shifted through a
// shift-and-add-three BCD converter, one bit per cycle, then the leading
// digit is picked. The first character is then registered into the output
// register; further characters follow one per cycle while the receiver
// is ready. An item gives n = 1..11 characters, and no new input beat is
// taken until its last character has been emitted. in_ready rises again
// while the last character still sits in the output register.
// A receiver stall holds the output register and pauses emission; nothing is
// lost. Reset (rst_n low, synchronous) returns to idle and empties the output.
module int_to_decimal_ascii_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_opcode,
  input  logic [i2da_pkg::WORD_BITS-1:0] in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_ascii_char,
  output logic                           out_is_last
);

  i2da_pkg::i2da_cmd_t cmd;
  i2da_pkg::i2da_sts_t sts;

  // Sequencer
  i2da_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Converter and output register
  i2da_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_opcode      (in_opcode),
    .in_value       (in_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_ascii_char (out_ascii_char),
    .out_is_last    (out_is_last)
  );

endmodule
